// ----- src/cpr_pkg.sv -----
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants and types for the clock page replacement core: default
// sizes, the frame-count register layout and the per-cell command bundle.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 20;

  // Frame-count register: 5 bits, reset to 16 frames.
  localparam int             CFG_W       = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // The reported frame index is always 4 bits wide.
  localparam int FRAME_OUT_W = 4;

  // Command broadcast from the sequencer to every frame cell.
  typedef struct packed {
    logic lookup;   // compare against the broadcast page, mark on match
    logic restart;  // move the hand token back to frame 0
    logic step;     // advance the hand token by one active frame
    logic load;     // the token holder takes the broadcast page
  } cpr_cmd_t;

endpackage : cpr_pkg

// ----- src/clock_page_replacement_core.sv -----
// ----------------------------------------------------------------------------
// clock_page_replacement_core
// Second-chance (clock) page replacement over a ring of frame cells.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  in_page
//   out_     output     out_valid/out_stall  out_hit, out_frame,
//                                            out_evicted_valid, out_evicted_page
//   cfg_     input      cfg_we               cfg_wdata (frames in use)
//
// A reference passes through accept, lookup and decide on a hit; a fault adds
// a walk in which the hand visits at most the active frame count plus one
// frames. The hand walk is the cost: the hand is a token that moves one cell
// along the ring per cycle until it stops on the frame to replace.
// Synchronous active-low reset empties all frames, clears all marks and puts
// the hand on frame 0. No clearing pass is needed.
// A result beat waits in the output register while out_stall is high; the
// next reference can be accepted meanwhile, and its own result waits for the
// register to free up.
// ----------------------------------------------------------------------------
module clock_page_replacement_core #(
  parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [PAGE_BITS-1:0]              in_page,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [cpr_pkg::FRAME_OUT_W-1:0]   out_frame,
  output logic                              out_evicted_valid,
  output logic [PAGE_BITS-1:0]              out_evicted_page,
  input  logic                              cfg_we,
  input  logic [cpr_pkg::CFG_W-1:0]         cfg_wdata
);
  import cpr_pkg::*;

  // Index width of a frame and width of the active frame count.
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_WALK
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PAGE_BITS-1:0]   pg_r, pg_nxt;
  logic [CFG_W-1:0]       cfg_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic [FRAME_OUT_W-1:0] out_frame_r, out_frame_nxt;
  logic                   out_ev_valid_r, out_ev_valid_nxt;
  logic [PAGE_BITS-1:0]   out_ev_page_r, out_ev_page_nxt;

  cpr_cmd_t               cmd;
  logic [NW-1:0]          n_act;
  logic [FRAMES-1:0]      act, last, home, tok, tok_in, val, mrk, mat;
  logic [PAGE_BITS-1:0]   cell_page [FRAMES];

  logic                   any_match, stop, out_free, hand_out;
  logic [IW-1:0]          hit_idx, tok_idx;
  logic                   vic_valid;
  logic [PAGE_BITS-1:0]   vic_page;

  // Active frame count: zero acts as one, anything above FRAMES saturates.
  always_comb begin
    if (cfg_r == '0) begin
      n_act = NW'(1);
    end else if (NW'(cfg_r) > NW'(FRAMES)) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = NW'(cfg_r);
    end
  end

  // Per-cell position flags. The last active cell hands the token back to
  // cell 0, closing the ring over the active frames only.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      act[i]  = (NW'(i) < n_act);
      last[i] = (NW'(i + 1) == n_act);
      home[i] = (i == 0);
    end
  end

  always_comb begin
    tok_in[0] = |(tok & last);
    for (int i = 1; i < FRAMES; i++) begin
      tok_in[i] = tok[i-1] & ~last[i-1];
    end
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    cpr_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .page_in (pg_r),
      .active  (act[g]),
      .home    (home[g]),
      .token_in(tok_in[g]),
      .token   (tok[g]),
      .valid   (val[g]),
      .mark    (mrk[g]),
      .match   (mat[g]),
      .page    (cell_page[g])
    );
  end

  // Lowest matching frame, position of the hand, and the frame under the hand.
  always_comb begin
    hit_idx  = '0;
    tok_idx  = '0;
    vic_page = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (mat[i]) begin
        hit_idx = IW'(i);
      end
    end
    for (int i = 0; i < FRAMES; i++) begin
      if (tok[i]) begin
        tok_idx = tok_idx | IW'(i);
      end
      vic_page = vic_page | (cell_page[i] & {PAGE_BITS{tok[i]}});
    end
  end

  assign any_match = |mat;
  assign hand_out  = |(tok & ~act);
  assign stop      = |(tok & ~(val & mrk));
  assign vic_valid = |(tok & val);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt        = state_r;
    pg_nxt           = pg_r;
    cmd              = '0;
    out_valid_nxt    = out_valid_r && out_stall;
    out_hit_nxt      = out_hit_r;
    out_frame_nxt    = out_frame_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pg_nxt    = in_page;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        if (any_match) begin
          if (out_free) begin
            out_valid_nxt    = 1'b1;
            out_hit_nxt      = 1'b1;
            out_frame_nxt    = FRAME_OUT_W'(hit_idx);
            out_ev_valid_nxt = 1'b0;
            out_ev_page_nxt  = '0;
            state_nxt        = S_IDLE;
          end
        end else begin
          // The hand may sit beyond a shrunken ring; restart it at frame 0.
          cmd.restart = hand_out;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        if (!stop) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.step         = 1'b1;
          cmd.load         = 1'b1;
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = 1'b0;
          out_frame_nxt    = FRAME_OUT_W'(tok_idx);
          out_ev_valid_nxt = vic_valid;
          out_ev_page_nxt  = vic_valid ? vic_page : '0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pg_r           <= pg_nxt;
    out_hit_r      <= out_hit_nxt;
    out_frame_r    <= out_frame_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame         = out_frame_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;

  // The hand is exactly one token in the ring.
  a_one_hand : assert property (@(posedge clk) disable iff (!rst_n) $onehot(tok))
    else $error("hand token is not one-hot");

  // During the walk the hand never visits an inactive frame.
  a_walk_active : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ((tok & ~act) == '0))
    else $error("hand walked outside the active frames");

  // A new result beat comes only from the decide step or the end of a walk.
  a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !($past(out_valid_r) && $past(out_stall))) |->
      ($past(state_r) == S_DECIDE || $past(state_r) == S_WALK))
    else $error("result beat appeared without a finished lookup");

  // A beat that evicts nothing, a hit or a fault into an empty frame, reports a zero page.
  a_ev_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ev_valid_r) |-> (out_ev_page_r == '0))
    else $error("evicted page set without an eviction");

endmodule : clock_page_replacement_core

// ----- src/cpr_cell.sv -----
// ----------------------------------------------------------------------------
// cpr_cell
// One frame of the clock ring: page number, reference mark, valid bit, the
// lookup match flag and the hand token, which moves to the next cell on a step.
// ----------------------------------------------------------------------------
module cpr_cell #(
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpr_pkg::cpr_cmd_t    cmd,
  input  logic [PAGE_BITS-1:0] page_in,
  input  logic                 active,
  input  logic                 home,
  input  logic                 token_in,
  output logic                 token,
  output logic                 valid,
  output logic                 mark,
  output logic                 match,
  output logic [PAGE_BITS-1:0] page
);
  import cpr_pkg::*;

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic                 mark_r;
  logic                 match_r;
  logic                 token_r;
  logic                 hit_now;

  assign hit_now = valid_r && active && (page_r == page_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
      match_r <= 1'b0;
      token_r <= home;
    end else begin
      if (cmd.lookup) begin
        match_r <= hit_now;
        if (hit_now) begin
          mark_r <= 1'b1;
        end
      end
      if (cmd.restart) begin
        token_r <= home;
      end else if (cmd.step) begin
        token_r <= token_in;
        if (token_r) begin
          // Passing over a frame clears its mark; a freshly loaded frame
          // also starts unmarked.
          mark_r <= 1'b0;
          if (cmd.load) begin
            valid_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && cmd.load && token_r) begin
      page_r <= page_in;
    end
  end

  assign token = token_r;
  assign valid = valid_r;
  assign mark  = mark_r;
  assign match = match_r;
  assign page  = page_r;

endmodule : cpr_cell

// ----- tb/tb_clock_page_replacement_core.sv -----
// ----------------------------------------------------------------------------
// tb_clock_page_replacement_core
// Self-checking testbench for the clock page replacement core. A directed
// table covers the corner cases of the frame table and of the frame-count
// register. Random phases follow, each with its own frame count and a small
// working set of pages, so that hits, faults and evictions all occur often.
// Every accepted result beat is checked against its typed outcome or else
// against a behavioral model of the frame table that runs alongside the core.
// ----------------------------------------------------------------------------
module tb_clock_page_replacement_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_CNT = cpr_pkg::FRAMES_DEF;
  localparam int PAGE_W    = cpr_pkg::PAGE_BITS_DEF;
  localparam int FRAME_W   = cpr_pkg::FRAME_OUT_W;
  localparam int CFG_W     = cpr_pkg::CFG_W;

  localparam int GAP_PERCENT    = 23;
  localparam int REFS_PER_PHASE = 90;
  localparam int POOL_DEPTH     = 40;
  localparam int N_DIRECTED     = 25;
  localparam int N_PHASES       = 10;

  // One result beat, laid out the way the core reports it.
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
  } ref_result_t;

  // A directed row either writes the frame-count register or sends one page
  // reference. Reference rows whose outcome is obvious carry it typed in; the
  // others take the outcome from the frame table model.
  typedef enum logic {ROW_REF, ROW_SET_FRAMES} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CFG_W-1:0]  frames;
    logic [PAGE_W-1:0] page;
    logic              typed;
    ref_result_t       want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PAGE_W-1:0] in_page = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_hit;
  logic [FRAME_W-1:0] out_frame;
  logic              out_evicted_valid;
  logic [PAGE_W-1:0] out_evicted_page;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  // Model of the frame table: resident page, reference mark and occupancy of
  // each frame, the clock hand and the frame-count register.
  logic [PAGE_W-1:0] held_page [FRAME_CNT];
  logic              ref_mark [FRAME_CNT];
  logic              occupied [FRAME_CNT];
  int                sweep_pos;
  logic [CFG_W-1:0]  frames_setting;

  ref_result_t       pending_results [$];
  int                mismatch_count = 0;
  bit                steady_flow = 1'b0;
  logic [PAGE_W-1:0] page_pool [POOL_DEPTH];

  //   kind            frames  page        typed  hit   frame  evicted  evicted page
  stim_row_t directed_rows [N_DIRECTED] = '{
    // Empty table: the first faults fill frames in order, nothing is evicted.
    '{ROW_REF,        5'd0,  20'h00000, 1'b1, '{1'b0, 4'd0, 1'b0, 20'h00000}},
    '{ROW_REF,        5'd0,  20'hFFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 20'h00000}},
    '{ROW_REF,        5'd0,  20'h00000, 1'b1, '{1'b1, 4'd0, 1'b0, 20'h00000}},
    '{ROW_REF,        5'd0,  20'h00005, 1'b1, '{1'b0, 4'd2, 1'b0, 20'h00000}},
    // Shrink to two frames while the hand sits on frame 3, so the next fault
    // has to restart the hand at frame 0.
    '{ROW_SET_FRAMES, 5'd2,  20'h00000, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'h00007, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'h00000, 1'b1, '{1'b1, 4'd0, 1'b0, 20'h00000}},
    '{ROW_REF,        5'd0,  20'h00007, 1'b1, '{1'b1, 4'd1, 1'b0, 20'h00000}},
    // Both active frames are marked: the hand goes all the way round.
    '{ROW_REF,        5'd0,  20'h00009, 1'b0, '0},
    // A frame count of zero behaves as one frame.
    '{ROW_SET_FRAMES, 5'd0,  20'h00000, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'h00003, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'h00003, 1'b1, '{1'b1, 4'd0, 1'b0, 20'h00000}},
    '{ROW_REF,        5'd0,  20'h00004, 1'b0, '0},
    // An oversized count saturates; frames left idle kept their pages.
    '{ROW_SET_FRAMES, 5'd31, 20'h00000, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'h00005, 1'b1, '{1'b1, 4'd2, 1'b0, 20'h00000}},
    '{ROW_REF,        5'd0,  20'h00007, 1'b1, '{1'b1, 4'd1, 1'b0, 20'h00000}},
    '{ROW_REF,        5'd0,  20'h00004, 1'b1, '{1'b1, 4'd0, 1'b0, 20'h00000}},
    // Load page 5 into frame 0 while only one frame is active, then grow
    // again: page 5 now sits in two frames and a hit reports the lower one.
    '{ROW_SET_FRAMES, 5'd1,  20'h00000, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'h00005, 1'b0, '0},
    '{ROW_SET_FRAMES, 5'd16, 20'h00000, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'h00005, 1'b1, '{1'b1, 4'd0, 1'b0, 20'h00000}},
    '{ROW_REF,        5'd0,  20'h80000, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'h5A5A5, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'h00007, 1'b0, '0},
    '{ROW_REF,        5'd0,  20'hFFFFF, 1'b0, '0}
  };

  // Frame counts of the random phases: the plain cases, the extremes and the
  // values that have to be clamped.
  logic [CFG_W-1:0] phase_frames [N_PHASES] = '{
    5'd3, 5'd16, 5'd1, 5'd8, 5'd0, 5'd31, 5'd2, 5'd12, 5'd20, 5'd16
  };

  clock_page_replacement_core #(
    .FRAMES    (FRAME_CNT),
    .PAGE_BITS (PAGE_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame         (out_frame),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset state of the model: every frame empty and unmarked, hand on frame 0,
  // all sixteen frames active.
  initial begin
    for (int k = 0; k < FRAME_CNT; k++) begin
      held_page[k] = '0;
      ref_mark[k]  = 1'b0;
      occupied[k]  = 1'b0;
    end
    sweep_pos      = 0;
    frames_setting = cpr_pkg::CFG_RESET;
  end

  function automatic bit take_gap();
    return !steady_flow && ($urandom_range(99) < GAP_PERCENT);
  endfunction

  // Applies one page reference to the model and returns the beat the core
  // must report for it.
  function automatic ref_result_t predict_reference(logic [PAGE_W-1:0] pg);
    int          span;
    int          slot;
    bit          found;
    ref_result_t res;
    span = frames_setting;
    if (span == 0) begin
      span = 1;
    end
    if (span > FRAME_CNT) begin
      span = FRAME_CNT;
    end
    res   = '0;
    found = 1'b0;
    slot  = 0;
    // Every active copy of the page gets its mark; the lowest frame is reported.
    for (int k = 0; k < span; k++) begin
      if (occupied[k] && held_page[k] == pg) begin
        if (!found) begin
          slot = k;
        end
        found       = 1'b1;
        ref_mark[k] = 1'b1;
      end
    end
    if (!found) begin
      // The hand may have been left outside the active range by a shrink.
      if (sweep_pos >= span) begin
        sweep_pos = 0;
      end
      // Second chance: marked frames lose their mark and are passed over.
      while (occupied[sweep_pos] && ref_mark[sweep_pos]) begin
        ref_mark[sweep_pos] = 1'b0;
        sweep_pos = (sweep_pos + 1) % span;
      end
      slot = sweep_pos;
      if (occupied[slot]) begin
        res.evicted_valid = 1'b1;
        res.evicted_page  = held_page[slot];
      end
      held_page[slot] = pg;
      ref_mark[slot]  = 1'b0;
      occupied[slot]  = 1'b1;
      sweep_pos = (sweep_pos + 1) % span;
    end
    res.hit   = found;
    res.frame = FRAME_W'(slot);
    return res;
  endfunction

  // Sends one reference beat. It is entered right after a rising edge and
  // returns right after the edge at which the beat was accepted, with
  // in_valid still high, so a following beat can go out back to back.
  task automatic send_reference(input logic [PAGE_W-1:0] pg, input logic typed,
                                input ref_result_t want);
    ref_result_t modeled;
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page  <= pg;
    do begin
      @(posedge clk);
    end while (in_stall);
    modeled = predict_reference(pg);
    pending_results.push_back(typed ? want : modeled);
  endtask

  // The register is only written once the core has delivered every result,
  // so no reference is in flight when the frame count changes.
  task automatic set_frames(input logic [CFG_W-1:0] count);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames_setting = count;
  endtask

  // Result side: check each accepted beat against the oldest expectation,
  // then decide whether to stall the next cycle.
  always @(posedge clk) begin
    ref_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: hit %0d frame %0d evicted %0d/%05h",
                 $time, out_hit, out_frame, out_evicted_valid, out_evicted_page);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %0d, got %0d", $time, want.hit, out_hit);
          mismatch_count++;
        end
        if (out_frame !== want.frame) begin
          $display("%0t: frame mismatch: expected %0d, got %0d",
                   $time, want.frame, out_frame);
          mismatch_count++;
        end
        if (out_evicted_valid !== want.evicted_valid) begin
          $display("%0t: evicted_valid mismatch: expected %0d, got %0d",
                   $time, want.evicted_valid, out_evicted_valid);
          mismatch_count++;
        end
        if (out_evicted_page !== want.evicted_page) begin
          $display("%0t: evicted_page mismatch: expected %05h, got %05h",
                   $time, want.evicted_page, out_evicted_page);
          mismatch_count++;
        end
      end
    end
    out_stall <= rst_n && take_gap();
  end

  // Stimulus: reset, the directed table, then the random phases.
  initial begin
    int               pool_n;
    logic [PAGE_W-1:0] pg;
    stim_row_t        row;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      page_pool[i] = PAGE_W'($urandom);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_SET_FRAMES) begin
        set_frames(row.frames);
      end else begin
        send_reference(row.page, row.typed, row.want);
      end
    end

    // Each phase keeps about half of the previous working set, so pages left
    // in frames that went idle come back into play when the count grows.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_frames(phase_frames[ph]);
      steady_flow = (ph == 1);
      pool_n = (phase_frames[ph] == 0) ? 1 :
               (phase_frames[ph] > FRAME_CNT) ? FRAME_CNT : phase_frames[ph];
      pool_n = pool_n + $urandom_range(pool_n + 2);
      for (int i = 0; i < POOL_DEPTH; i++) begin
        if ($urandom_range(1) == 1) begin
          page_pool[i] = PAGE_W'($urandom);
        end
      end
      for (int n = 0; n < REFS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 12) begin
          pg = PAGE_W'($urandom);
        end else begin
          pg = page_pool[$urandom_range(pool_n - 1)];
        end
        send_reference(pg, 1'b0, '0);
      end
    end
    steady_flow = 1'b0;
    in_valid <= 1'b0;

    // Drain, with a bound, then let the core sit a little longer so that any
    // stray beat would still be caught.
    for (int c = 0; c < 5000 && pending_results.size() != 0; c++) begin
      @(posedge clk);
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule : tb_clock_page_replacement_core

// ----- filelist.f -----
src/cpr_pkg.sv
src/cpr_cell.sv
src/clock_page_replacement_core.sv
tb/tb_clock_page_replacement_core.sv
